// File: src/nmgga_pkg.sv
package nmgga_pkg;

    // Field numbers within a GGA sentence (comma count)
    localparam logic [3:0] FLD_TIME = 4'd1;
    localparam logic [3:0] FLD_LAT  = 4'd2;
    localparam logic [3:0] FLD_NS   = 4'd3;
    localparam logic [3:0] FLD_LON  = 4'd4;
    localparam logic [3:0] FLD_EW   = 4'd5;
    localparam logic [3:0] FLD_ALT  = 4'd9;
    localparam logic [3:0] FLD_MAX  = 4'd15;
    localparam logic [3:0] CIF_MAX  = 4'd15;

    // Degree digit counts
    localparam logic [3:0] LAT_DEG_CHARS = 4'd2;
    localparam logic [3:0] LON_DEG_CHARS = 4'd3;

    // Characters of interest
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Widths and limits
    localparam int          DEG_W         = 10;
    localparam int          TIME_W        = 24;
    localparam int          ALT_W         = 20;
    localparam int          POS_W         = 30;
    localparam int          LAT_W         = 27;
    localparam logic [23:0] TIME_SAT      = 24'h999999;
    localparam logic [19:0] ALT_CAP       = 20'd999990;
    localparam logic [29:0] MICRO_PER_DEG = 30'd1000000;

    typedef enum logic [1:0] {
        CLOSE_NONE,
        CLOSE_LAT,
        CLOSE_LON
    } t_close_sel;

    // Control for one event leaving the character parser
    typedef struct packed {
        t_close_sel close_sel;
        logic       is_end;
    } t_ev_ctl;

    // Sentence-level values captured on the last character
    typedef struct packed {
        logic [TIME_W-1:0] time_bcd;
        logic [ALT_W-1:0]  alt_mag;
        logic              alt_neg;
        logic [7:0]        lat_dir;
        logic [7:0]        lon_dir;
        logic              lat_vld;
        logic              lon_vld;
        logic              alt_vld;
    } t_end_info;

    function automatic longint unsigned pow10(input int n);
        longint unsigned v;
        v = 1;
        for (int k = 0; k < n; k++) begin
            v = v * 10;
        end
        return v;
    endfunction

    // Bits for a minute accumulator that stays below 100 * 10^frac
    function automatic int min_acc_width(input int frac);
        return $clog2(100 * pow10(frac));
    endfunction

endpackage

// File: src/nmgga_parser.sv
module nmgga_parser
    import nmgga_pkg::*;
#(
    parameter int MINUTE_FRAC_DIGITS = 5,
    parameter int MINUTE_CHARS       = 8,
    parameter int ALT_CHARS          = 5,
    localparam int MIN_W             = min_acc_width(MINUTE_FRAC_DIGITS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_ch,
    input  logic             i_end_of_sentence,
    output logic             o_ev_valid,
    input  logic             i_ev_stall,
    output t_ev_ctl          o_ev_ctl,
    output logic [DEG_W-1:0] o_ev_deg,
    output logic [MIN_W-1:0] o_ev_min,
    output t_end_info        o_ev_info
);

    localparam longint unsigned SCALE      = pow10(MINUTE_FRAC_DIGITS);
    localparam logic [MIN_W-1:0] MIN_CAP   = MIN_W'(100 * SCALE - 1);
    localparam logic [MIN_W-1:0] MIN_SCALE = MIN_W'(SCALE);
    localparam logic [2:0] FRAC_LIMIT      = 3'(MINUTE_FRAC_DIGITS);
    localparam logic [3:0] MIN_SPAN        = 4'(MINUTE_CHARS);
    localparam logic [3:0] ALT_SPAN        = 4'(ALT_CHARS);

    typedef struct packed {
        logic [3:0]        field;
        logic [3:0]        cif;
        logic [TIME_W-1:0] time_bcd;
        logic [DEG_W-1:0]  deg;
        logic [MIN_W-1:0]  mins;
        logic [2:0]        frac_cnt;
        logic              point;
        logic [ALT_W-1:0]  alt_mag;
        logic              alt_neg;
        logic [7:0]        lat_dir;
        logic [7:0]        lon_dir;
        logic              lat_vld;
        logic              lon_vld;
        logic              alt_vld;
        logic              deg_end;
        logic              num_end;
    } t_prs_state;

    t_prs_state r_st, p_st, n_st;

    logic             r_ev_valid;
    t_ev_ctl          r_ev_ctl;
    logic [DEG_W-1:0] r_ev_deg;
    logic [MIN_W-1:0] r_ev_min;
    t_end_info        r_ev_info;

    logic             acc;
    logic             is_digit, is_comma, is_point, is_sign;
    logic [3:0]       dig;
    logic [3:0]       deg_len;
    logic             in_pos, in_alt;
    t_close_sel       ev_close;
    logic             ev_hit;

    logic [TIME_W-1:0] time_next;
    logic [DEG_W-1:0]  deg_next;
    logic [MIN_W+3:0]  min_int_sum;
    logic [MIN_W:0]    min_frac_sum;
    logic [MIN_W-1:0]  min_int_sat, min_frac_sat;
    logic [23:0]       alt_int_sum, alt_frac_sum;
    logic [ALT_W-1:0]  alt_int_sat, alt_frac_sat;
    logic [MIN_W-1:0]  frac_wt [8];

    // Weight of each minute fraction digit
    for (genvar g = 0; g < 8; g++) begin : g_frac_wt
        assign frac_wt[g] = (g < MINUTE_FRAC_DIGITS)
                            ? MIN_W'(pow10(MINUTE_FRAC_DIGITS - 1 - g)) : '0;
    end

    // Handshake: the event register must be free to take a transfer
    assign o_stall = r_ev_valid && i_ev_stall;
    assign acc     = i_valid && !o_stall;

    // Character classes
    assign is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign is_comma = (i_ch == CH_COMMA);
    assign is_point = (i_ch == CH_POINT);
    assign is_sign  = (i_ch == CH_MINUS) || (i_ch == CH_PLUS);
    assign dig      = i_ch[3:0];

    // Digit accumulation candidates
    assign time_next = (r_st.time_bcd[23:20] != 4'd0) ? TIME_SAT
                                                       : {r_st.time_bcd[19:0], dig};
    assign deg_next  = r_st.deg * DEG_W'(10) + DEG_W'(dig);

    assign min_int_sum  = (MIN_W+4)'(r_st.mins) * (MIN_W+4)'(10)
                        + (MIN_W+4)'(dig) * (MIN_W+4)'(MIN_SCALE);
    assign min_frac_sum = (MIN_W+1)'(r_st.mins)
                        + (MIN_W+1)'(dig) * (MIN_W+1)'(frac_wt[r_st.frac_cnt]);
    assign min_int_sat  = (min_int_sum > (MIN_W+4)'(MIN_CAP)) ? MIN_CAP
                                                               : min_int_sum[MIN_W-1:0];
    assign min_frac_sat = (min_frac_sum > (MIN_W+1)'(MIN_CAP)) ? MIN_CAP
                                                                : min_frac_sum[MIN_W-1:0];

    assign alt_int_sum  = 24'(r_st.alt_mag) * 24'd10 + 24'(dig) * 24'd10;
    assign alt_frac_sum = 24'(r_st.alt_mag) + 24'(dig);
    assign alt_int_sat  = (alt_int_sum > 24'(ALT_CAP)) ? ALT_CAP : alt_int_sum[ALT_W-1:0];
    assign alt_frac_sat = (alt_frac_sum > 24'(ALT_CAP)) ? ALT_CAP : alt_frac_sum[ALT_W-1:0];

    // Per-character state update, before field clear and sentence reset
    always_comb begin
        p_st    = r_st;
        in_pos  = 1'b0;
        in_alt  = 1'b0;
        deg_len = (r_st.field == FLD_LAT) ? LAT_DEG_CHARS : LON_DEG_CHARS;

        if (!is_comma) begin
            if (r_st.cif != CIF_MAX) begin
                p_st.cif = r_st.cif + 4'd1;
            end
            unique case (r_st.field)
                FLD_TIME: begin
                    if (!r_st.num_end) begin
                        if (is_digit) begin
                            p_st.time_bcd = time_next;
                        end else begin
                            p_st.num_end = 1'b1;
                        end
                    end
                end
                FLD_LAT: begin
                    if (r_st.cif == 4'd0) begin
                        p_st.lat_vld = 1'b1;
                    end
                    in_pos = 1'b1;
                end
                FLD_NS: begin
                    if (r_st.cif == 4'd0) begin
                        p_st.lat_dir = i_ch;
                    end
                end
                FLD_LON: begin
                    if (r_st.cif == 4'd0) begin
                        p_st.lon_vld = 1'b1;
                    end
                    in_pos = 1'b1;
                end
                FLD_EW: begin
                    if (r_st.cif == 4'd0) begin
                        p_st.lon_dir = i_ch;
                    end
                end
                FLD_ALT: begin
                    if (r_st.cif == 4'd0) begin
                        p_st.alt_vld = 1'b1;
                    end
                    in_alt = 1'b1;
                end
                default: ;
            endcase
        end

        // Position: degree digits, then the minute span
        if (in_pos) begin
            if (r_st.cif < deg_len) begin
                if (!r_st.deg_end) begin
                    if (is_digit) begin
                        p_st.deg = deg_next;
                    end else begin
                        p_st.deg_end = 1'b1;
                    end
                end
            end else if (r_st.cif < deg_len + MIN_SPAN) begin
                if (!r_st.num_end) begin
                    if (is_digit) begin
                        if (!r_st.point) begin
                            p_st.mins = min_int_sat;
                        end else if (r_st.frac_cnt < FRAC_LIMIT) begin
                            p_st.mins     = min_frac_sat;
                            p_st.frac_cnt = r_st.frac_cnt + 3'd1;
                        end
                    end else if (is_point && !r_st.point) begin
                        p_st.point = 1'b1;
                    end else begin
                        p_st.num_end = 1'b1;
                    end
                end
            end
        end

        // Altitude: optional sign, digits, one kept fraction digit
        if (in_alt && (r_st.cif < ALT_SPAN) && !r_st.num_end) begin
            if ((r_st.cif == 4'd0) && is_sign) begin
                p_st.alt_neg = (i_ch == CH_MINUS);
            end else if (is_digit) begin
                if (!r_st.point) begin
                    p_st.alt_mag = alt_int_sat;
                end else if (r_st.frac_cnt == 3'd0) begin
                    p_st.alt_mag  = alt_frac_sat;
                    p_st.frac_cnt = 3'd1;
                end
            end else if (is_point && !r_st.point) begin
                p_st.point = 1'b1;
            end else begin
                p_st.num_end = 1'b1;
            end
        end
    end

    // Field clear on comma, full reset after the last character
    always_comb begin
        n_st = p_st;
        if (i_end_of_sentence) begin
            n_st = '0;
        end else if (is_comma) begin
            n_st.field    = (r_st.field != FLD_MAX) ? r_st.field + 4'd1 : r_st.field;
            n_st.cif      = '0;
            n_st.deg      = '0;
            n_st.mins     = '0;
            n_st.frac_cnt = '0;
            n_st.point    = 1'b0;
            n_st.deg_end  = 1'b0;
            n_st.num_end  = 1'b0;
        end
    end

    // A position field closes on its comma or on the last character
    always_comb begin
        ev_close = CLOSE_NONE;
        if (is_comma || i_end_of_sentence) begin
            if (r_st.field == FLD_LAT) begin
                ev_close = CLOSE_LAT;
            end else if (r_st.field == FLD_LON) begin
                ev_close = CLOSE_LON;
            end
        end
    end

    assign ev_hit = i_end_of_sentence || (ev_close != CLOSE_NONE);

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (acc) begin
            r_st <= n_st;
        end
    end

    // Event register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_valid <= 1'b0;
        end else if (!o_stall) begin
            r_ev_valid <= acc && ev_hit;
        end
    end

    // Event payload
    always_ff @(posedge i_clk) begin
        if (acc && ev_hit) begin
            r_ev_ctl.close_sel <= ev_close;
            r_ev_ctl.is_end    <= i_end_of_sentence;
            r_ev_deg           <= p_st.deg;
            r_ev_min           <= p_st.mins;
            r_ev_info.time_bcd <= p_st.time_bcd;
            r_ev_info.alt_mag  <= p_st.alt_mag;
            r_ev_info.alt_neg  <= p_st.alt_neg;
            r_ev_info.lat_dir  <= p_st.lat_dir;
            r_ev_info.lon_dir  <= p_st.lon_dir;
            r_ev_info.lat_vld  <= p_st.lat_vld;
            r_ev_info.lon_vld  <= p_st.lon_vld;
            r_ev_info.alt_vld  <= p_st.alt_vld;
        end
    end

    assign o_ev_valid = r_ev_valid;
    assign o_ev_ctl   = r_ev_ctl;
    assign o_ev_deg   = r_ev_deg;
    assign o_ev_min   = r_ev_min;
    assign o_ev_info  = r_ev_info;

endmodule

// File: src/nmgga_conv.sv
module nmgga_conv
    import nmgga_pkg::*;
#(
    parameter int MINUTE_FRAC_DIGITS = 5,
    localparam int MIN_W             = min_acc_width(MINUTE_FRAC_DIGITS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ev_valid,
    output logic                o_ev_stall,
    input  t_ev_ctl             i_ev_ctl,
    input  logic [DEG_W-1:0]    i_ev_deg,
    input  logic [MIN_W-1:0]    i_ev_min,
    input  t_end_info           i_ev_info,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [6:0]          o_hours,
    output logic [6:0]          o_mins,
    output logic [6:0]          o_secs,
    output logic [LAT_W-1:0]    o_latitude_micro,
    output logic [7:0]          o_lat_dir,
    output logic                o_lat_valid,
    output logic [POS_W-1:0]    o_longitude_micro,
    output logic [7:0]          o_lon_dir,
    output logic                o_lon_valid,
    output logic signed [20:0]  o_altitude_tenths,
    output logic                o_alt_valid
);

    // micro = deg * 1e6 + floor(min * KMUL / DIV), min scaled by 10^frac
    localparam longint unsigned SCALE = pow10(MINUTE_FRAC_DIGITS);
    localparam longint unsigned KMUL  = (MINUTE_FRAC_DIGITS <= 5)
                                        ? pow10(5 - MINUTE_FRAC_DIGITS) : 1;
    localparam longint unsigned DIV   = (MINUTE_FRAC_DIGITS <= 5) ? 6 : 60;
    localparam int              X_W   = $clog2(100 * SCALE * KMUL);
    localparam longint unsigned RECIP = (64'd1 << X_W) / DIV;
    localparam longint unsigned PMUL  = KMUL * RECIP;
    localparam int              PM_W  = $clog2(PMUL + 1);
    localparam int              P_W   = MIN_W + PM_W;
    localparam int              R_W   = $clog2(2 * DIV);

    // Stage 1: products
    logic             r_mp_valid;
    t_ev_ctl          r_mp_ctl;
    t_end_info        r_mp_info;
    logic [P_W-1:0]   r_mp_p;
    logic [X_W-1:0]   r_mp_x;
    logic [POS_W-1:0] r_mp_dp;

    // Stage 2: quotient estimate and remainder
    logic             r_qr_valid;
    t_ev_ctl          r_qr_ctl;
    t_end_info        r_qr_info;
    logic [X_W-1:0]   r_qr_q;
    logic [R_W-1:0]   r_qr_r;
    logic [POS_W-1:0] r_qr_dp;

    // Held positions and result register
    logic [LAT_W-1:0]  r_held_lat;
    logic [POS_W-1:0]  r_held_lon;
    logic              r_out_valid;
    logic [6:0]        r_out_hours, r_out_mins, r_out_secs;
    logic [LAT_W-1:0]  r_out_lat;
    logic [POS_W-1:0]  r_out_lon;
    logic [7:0]        r_out_lat_dir, r_out_lon_dir;
    logic              r_out_lat_vld, r_out_lon_vld, r_out_alt_vld;
    logic signed [20:0] r_out_alt;

    logic             out_free, qr_go, qr_stall, mp_stall;
    logic [X_W-1:0]   q_est;
    logic [X_W-1:0]   r_full;
    logic [POS_W-1:0] pos_val;
    logic [20:0]      alt_val;

    // Backpressure chain; close-only events retire without a result
    assign out_free   = !r_out_valid || !i_stall;
    assign qr_go      = r_qr_valid && (!r_qr_ctl.is_end || out_free);
    assign qr_stall   = r_qr_valid && !qr_go;
    assign mp_stall   = r_mp_valid && qr_stall;
    assign o_ev_stall = mp_stall;

    // Reciprocal estimate is q or q-1; remainder fixes it
    assign q_est   = X_W'(r_mp_p >> X_W);
    assign r_full  = r_mp_x - X_W'(q_est * X_W'(DIV));
    assign pos_val = r_qr_dp + POS_W'(r_qr_q) + POS_W'(r_qr_r >= R_W'(DIV));
    assign alt_val = r_qr_info.alt_neg ? (21'd0 - 21'(r_qr_info.alt_mag))
                                       : 21'(r_qr_info.alt_mag);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mp_valid  <= 1'b0;
            r_qr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_held_lat  <= '0;
            r_held_lon  <= '0;
        end else begin
            if (!mp_stall) begin
                r_mp_valid <= i_ev_valid;
            end
            if (!qr_stall) begin
                r_qr_valid <= r_mp_valid;
            end
            if (out_free) begin
                r_out_valid <= qr_go && r_qr_ctl.is_end;
            end
            if (qr_go) begin
                if (r_qr_ctl.is_end) begin
                    r_held_lat <= '0;
                    r_held_lon <= '0;
                end else if (r_qr_ctl.close_sel == CLOSE_LAT) begin
                    r_held_lat <= pos_val[LAT_W-1:0];
                end else if (r_qr_ctl.close_sel == CLOSE_LON) begin
                    r_held_lon <= pos_val;
                end
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (i_ev_valid && !mp_stall) begin
            r_mp_ctl  <= i_ev_ctl;
            r_mp_info <= i_ev_info;
            r_mp_p    <= P_W'(i_ev_min) * P_W'(PMUL);
            r_mp_x    <= X_W'(i_ev_min) * X_W'(KMUL);
            r_mp_dp   <= POS_W'(i_ev_deg) * MICRO_PER_DEG;
        end
        if (r_mp_valid && !qr_stall) begin
            r_qr_ctl  <= r_mp_ctl;
            r_qr_info <= r_mp_info;
            r_qr_q    <= q_est;
            r_qr_r    <= r_full[R_W-1:0];
            r_qr_dp   <= r_mp_dp;
        end
        if (qr_go && r_qr_ctl.is_end) begin
            r_out_hours   <= 7'(r_qr_info.time_bcd[23:20]) * 7'd10
                           + 7'(r_qr_info.time_bcd[19:16]);
            r_out_mins    <= 7'(r_qr_info.time_bcd[15:12]) * 7'd10
                           + 7'(r_qr_info.time_bcd[11:8]);
            r_out_secs    <= 7'(r_qr_info.time_bcd[7:4]) * 7'd10
                           + 7'(r_qr_info.time_bcd[3:0]);
            r_out_lat     <= (r_qr_ctl.close_sel == CLOSE_LAT) ? pos_val[LAT_W-1:0]
                                                                : r_held_lat;
            r_out_lon     <= (r_qr_ctl.close_sel == CLOSE_LON) ? pos_val : r_held_lon;
            r_out_lat_dir <= r_qr_info.lat_dir;
            r_out_lon_dir <= r_qr_info.lon_dir;
            r_out_lat_vld <= r_qr_info.lat_vld;
            r_out_lon_vld <= r_qr_info.lon_vld;
            r_out_alt_vld <= r_qr_info.alt_vld;
            r_out_alt     <= alt_val;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_hours           = r_out_hours;
    assign o_mins            = r_out_mins;
    assign o_secs            = r_out_secs;
    assign o_latitude_micro  = r_out_lat;
    assign o_lat_dir         = r_out_lat_dir;
    assign o_lat_valid       = r_out_lat_vld;
    assign o_longitude_micro = r_out_lon;
    assign o_lon_dir         = r_out_lon_dir;
    assign o_lon_valid       = r_out_lon_vld;
    assign o_altitude_tenths = r_out_alt;
    assign o_alt_valid       = r_out_alt_vld;

endmodule

// File: src/nmea_gga_field_parser_unit.sv
// GGA sentence field parser. Feed one character per transfer, with
// i_end_of_sentence set on the last one; one character is taken every cycle
// while o_stall is low, and a sentence's result is built as its last character
// passes through the event, product and quotient registers into the
// result register. Commas split fields: time (hhmmss, fraction dropped),
// latitude (2 degree digits), N/S, longitude (3 degree digits), E/W and
// altitude (first ALT_CHARS characters, tenths of a meter, optional sign).
// Positions come out in micro-degrees, truncated, from minutes kept to
// MINUTE_FRAC_DIGITS decimals over MINUTE_CHARS characters. Empty fields give
// zero values with their valid flag clear. The block keeps taking characters
// while a result waits; o_stall rises only when a position close or a
// sentence end cannot move into the conversion pipeline.
module nmea_gga_field_parser_unit
    import nmgga_pkg::*;
#(
    parameter int MINUTE_FRAC_DIGITS = 5,
    parameter int MINUTE_CHARS       = 8,
    parameter int ALT_CHARS          = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_ch,
    input  logic               i_end_of_sentence,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [6:0]         o_hours,
    output logic [6:0]         o_mins,
    output logic [6:0]         o_secs,
    output logic [26:0]        o_latitude_micro,
    output logic [7:0]         o_lat_dir,
    output logic               o_lat_valid,
    output logic [29:0]        o_longitude_micro,
    output logic [7:0]         o_lon_dir,
    output logic               o_lon_valid,
    output logic signed [20:0] o_altitude_tenths,
    output logic               o_alt_valid
);

    localparam int MIN_W = min_acc_width(MINUTE_FRAC_DIGITS);

    logic             ev_valid;
    logic             ev_stall;
    t_ev_ctl          ev_ctl;
    logic [DEG_W-1:0] ev_deg;
    logic [MIN_W-1:0] ev_min;
    t_end_info        ev_info;

    // Character parser
    nmgga_parser #(
        .MINUTE_FRAC_DIGITS (MINUTE_FRAC_DIGITS),
        .MINUTE_CHARS       (MINUTE_CHARS),
        .ALT_CHARS          (ALT_CHARS)
    ) u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_ch              (i_ch),
        .i_end_of_sentence (i_end_of_sentence),
        .o_ev_valid        (ev_valid),
        .i_ev_stall        (ev_stall),
        .o_ev_ctl          (ev_ctl),
        .o_ev_deg          (ev_deg),
        .o_ev_min          (ev_min),
        .o_ev_info         (ev_info)
    );

    // Position conversion and result register
    nmgga_conv #(
        .MINUTE_FRAC_DIGITS (MINUTE_FRAC_DIGITS)
    ) u_conv (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ev_valid        (ev_valid),
        .o_ev_stall        (ev_stall),
        .i_ev_ctl          (ev_ctl),
        .i_ev_deg          (ev_deg),
        .i_ev_min          (ev_min),
        .i_ev_info         (ev_info),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_hours           (o_hours),
        .o_mins            (o_mins),
        .o_secs            (o_secs),
        .o_latitude_micro  (o_latitude_micro),
        .o_lat_dir         (o_lat_dir),
        .o_lat_valid       (o_lat_valid),
        .o_longitude_micro (o_longitude_micro),
        .o_lon_dir         (o_lon_dir),
        .o_lon_valid       (o_lon_valid),
        .o_altitude_tenths (o_altitude_tenths),
        .o_alt_valid       (o_alt_valid)
    );

endmodule

// File: src/nmgga_checker.sv
module nmgga_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic [6:0]         o_hours,
    input logic [6:0]         o_mins,
    input logic [6:0]         o_secs,
    input logic [26:0]        o_latitude_micro,
    input logic               o_lat_valid,
    input logic [29:0]        o_longitude_micro,
    input logic               o_lon_valid,
    input logic signed [20:0] o_altitude_tenths,
    input logic               o_alt_valid
);

    // No result is presented right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A stalled result holds its values
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hours) && $stable(o_mins)
            && $stable(o_secs) && $stable(o_latitude_micro)
            && $stable(o_longitude_micro) && $stable(o_altitude_tenths))
        else $error("stalled result changed");

    // Time digits come from BCD pairs
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hours <= 7'd99) && (o_mins <= 7'd99) && (o_secs <= 7'd99))
        else $error("time field out of range");

    // Position bounds from degree digit count and minute saturation
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_latitude_micro <= 27'd100666666)
            && (o_longitude_micro <= 30'd1000666666))
        else $error("position out of range");

    // An empty field reads as zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_lat_valid || (o_latitude_micro == 27'd0))
            && (o_lon_valid || (o_longitude_micro == 30'd0))
            && (o_alt_valid || (o_altitude_tenths == 21'sd0)))
        else $error("empty field gave a nonzero value");

endmodule

bind nmea_gga_field_parser_unit nmgga_checker u_nmgga_checker (.*);
